// ===== src/dfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared constants, result type and the powers-of-ten table of the
// signed decimal format printer.
// ----------------------------------------------------------------------------
package dfp_pkg;

    localparam int DFP_MAX_DIGITS = 10;
    localparam int CHAR_W         = 8;
    localparam int DATA_W         = 32;
    localparam int POW_W          = DATA_W + 1;
    localparam int MULT_W         = POW_W + 4;
    localparam int DIGIT_W        = 4;
    localparam int DFP_RADIX      = 10;

    localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_D       = 8'h64;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              done_res;
        logic              error;
        logic [DATA_W-1:0] char_count;
        logic              last;
    } dfp_result_t;

    // 10^k, clipped to 2^32 once it no longer fits a 32-bit magnitude
    function automatic logic [POW_W-1:0] pow10_sat(input int k);
        logic [POW_W-1:0] p;
        case (k)
            0:       p = 33'd1;
            1:       p = 33'd10;
            2:       p = 33'd100;
            3:       p = 33'd1000;
            4:       p = 33'd10000;
            5:       p = 33'd100000;
            6:       p = 33'd1000000;
            7:       p = 33'd10000000;
            8:       p = 33'd100000000;
            9:       p = 33'd1000000000;
            default: p = 33'h1_0000_0000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/dfp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_in_if
// Format character channel: one format byte and one argument per beat.
// ----------------------------------------------------------------------------
interface dfp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  fmt_char;
    logic signed [31:0] arg_value;

    modport source (output valid, output fmt_char, output arg_value, input ready);
    modport sink   (input valid, input fmt_char, input arg_value, output ready);
endinterface

// ===== src/dfp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_out_if
// Result channel: one emitted character, error or done marker per beat.
// ----------------------------------------------------------------------------
interface dfp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        char_valid;
    logic        done_res;
    logic        error;
    logic [31:0] char_count;
    logic        last;

    modport source (output valid, output out_char, output char_valid, output done_res,
                    output error, output char_count, output last, input ready);
    modport sink   (input valid, input out_char, input char_valid, input done_res,
                    input error, input char_count, input last, output ready);
endinterface

// ===== src/dfp_digit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfp_digit_unit
// One decimal digit step: picks the digit of weight 10^k from the running
// magnitude and returns the remainder.
// ----------------------------------------------------------------------------
module dfp_digit_unit
    import dfp_pkg::*;
#(
    parameter int MAX_DIGITS = DFP_MAX_DIGITS,
    localparam int K_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
)
(
    input  logic [K_W-1:0]     k,
    input  logic [DATA_W-1:0]  mag,
    output logic [DIGIT_W-1:0] digit,
    output logic [DATA_W-1:0]  rem
);

    always_comb
    begin : digit_sel
        logic [POW_W-1:0]  pow;
        logic [MULT_W-1:0] mult;
        logic [MULT_W-1:0] sub;
        pow   = pow10_sat(int'(k));
        digit = '0;
        sub   = '0;
        for (int j = 1; j < DFP_RADIX; j++)
        begin
            mult = MULT_W'(pow) * MULT_W'(j);
            if (MULT_W'(mag) >= mult)
            begin
                digit = DIGIT_W'(j);
                sub   = mult;
            end
        end
        rem = mag - sub[DATA_W-1:0];
    end

endmodule

// ===== src/decimal_format_printer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_format_printer
// Formats a character stream with %d conversions of a 32-bit signed
// argument into ASCII result beats, with error and done markers.
// ----------------------------------------------------------------------------
// ordinary byte, '%', error: no busy state; any result beat is registered
// %d: a setup step (emits '-' if negative), then MAX_DIGITS digit steps,
//   one shared digit unit pass per cycle unless stalled, leading zeros skipped
// nul after '%': an error beat, then a done beat
// output stalls hold the sequencer; a byte is taken into a hold register meanwhile
// reset: async active low, clears state, count and output valid
module decimal_format_printer
    import dfp_pkg::*;
#(
    parameter int MAX_DIGITS = DFP_MAX_DIGITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    dfp_in_if.sink    fmt_in,
    dfp_out_if.source res_out
);

    localparam int K_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [K_W-1:0] K_TOP = K_W'(MAX_DIGITS - 1);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_HOLD    = 2'd1;
    localparam logic [1:0] S_DIGIT   = 2'd2;
    localparam logic [1:0] S_NULDONE = 2'd3;

    logic [1:0]         state_reg,     state_next;
    logic               pending_reg,   pending_next;
    logic               halted_reg,    halted_next;
    logic [DATA_W-1:0]  count_reg,     count_next;
    logic [CHAR_W-1:0]  hold_ch_reg,   hold_ch_next;
    logic [DATA_W-1:0]  hold_arg_reg,  hold_arg_next;
    logic [DATA_W-1:0]  mag_reg,       mag_next;
    logic [K_W-1:0]     k_reg,         k_next;
    logic               started_reg,   started_next;
    dfp_result_t        out_reg,       out_next;
    logic               out_valid_reg, out_valid_next;

    logic               slot_free;
    logic               in_beat;
    logic               go;
    logic               load;
    logic [CHAR_W-1:0]  cur_ch;
    logic [DATA_W-1:0]  cur_arg;
    logic [DATA_W-1:0]  mag_abs;
    logic [POW_W-1:0]   sat_lim;
    logic [DATA_W-1:0]  count_inc;
    logic [DIGIT_W-1:0] digit;
    logic [DATA_W-1:0]  rem;

    dfp_digit_unit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit (
        .k     (k_reg),
        .mag   (mag_reg),
        .digit (digit),
        .rem   (rem)
    );

    assign fmt_in.ready = (state_reg == S_IDLE);
    assign in_beat      = fmt_in.valid && fmt_in.ready;
    assign slot_free    = !out_valid_reg || res_out.ready;
    assign go           = (in_beat && slot_free) || ((state_reg == S_HOLD) && slot_free);
    assign cur_ch       = (state_reg == S_HOLD) ? hold_ch_reg : fmt_in.fmt_char;
    assign cur_arg      = (state_reg == S_HOLD) ? hold_arg_reg : DATA_W'(fmt_in.arg_value);
    assign mag_abs      = cur_arg[DATA_W-1] ? (~cur_arg + 32'd1) : cur_arg;
    assign sat_lim      = pow10_sat(MAX_DIGITS);
    assign count_inc    = (&count_reg) ? count_reg : count_reg + 32'd1;

    always_comb
    begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        halted_next   = halted_reg;
        count_next    = count_reg;
        hold_ch_next  = hold_ch_reg;
        hold_arg_next = hold_arg_reg;
        mag_next      = mag_reg;
        k_next        = k_reg;
        started_next  = started_reg;
        out_next      = out_reg;
        load          = 1'b0;

        if (in_beat && !slot_free)
        begin
            hold_ch_next  = fmt_in.fmt_char;
            hold_arg_next = DATA_W'(fmt_in.arg_value);
            state_next    = S_HOLD;
        end

        if (go)
        begin
            state_next = S_IDLE;
            priority if (cur_ch == CH_NUL)
            begin
                load = 1'b1;
                if (pending_reg && !halted_reg)
                begin
                    out_next   = '{out_char: CH_NUL, char_valid: 1'b0, done_res: 1'b0,
                                   error: 1'b1, char_count: count_reg, last: 1'b0};
                    state_next = S_NULDONE;
                end
                else
                begin
                    out_next     = '{out_char: CH_NUL, char_valid: 1'b0, done_res: 1'b1,
                                     error: 1'b0, char_count: count_reg, last: 1'b1};
                    count_next   = '0;
                    pending_next = 1'b0;
                    halted_next  = 1'b0;
                end
            end
            else if (halted_reg)
            begin
                // dropped until end of string
            end
            else if (pending_reg)
            begin
                pending_next = 1'b0;
                if (cur_ch == CH_D)
                begin
                    if ({1'b0, mag_abs} >= sat_lim)
                        mag_next = sat_lim[DATA_W-1:0] - 32'd1;
                    else
                        mag_next = mag_abs;
                    k_next       = K_TOP;
                    started_next = 1'b0;
                    state_next   = S_DIGIT;
                    if (cur_arg[DATA_W-1])
                    begin
                        load       = 1'b1;
                        count_next = count_inc;
                        out_next   = '{out_char: CH_MINUS, char_valid: 1'b1, done_res: 1'b0,
                                       error: 1'b0, char_count: count_inc, last: 1'b0};
                    end
                end
                else
                begin
                    load        = 1'b1;
                    halted_next = 1'b1;
                    out_next    = '{out_char: cur_ch, char_valid: 1'b0, done_res: 1'b0,
                                    error: 1'b1, char_count: count_reg, last: 1'b1};
                end
            end
            else if (cur_ch == CH_PERCENT)
            begin
                pending_next = 1'b1;
            end
            else
            begin
                load       = 1'b1;
                count_next = count_inc;
                out_next   = '{out_char: cur_ch, char_valid: 1'b1, done_res: 1'b0,
                               error: 1'b0, char_count: count_inc, last: 1'b1};
            end
        end

        if ((state_reg == S_DIGIT) && slot_free)
        begin
            if ((digit != '0) || started_reg || (k_reg == '0))
            begin
                load         = 1'b1;
                started_next = 1'b1;
                count_next   = count_inc;
                out_next     = '{out_char: CH_ZERO + CHAR_W'(digit), char_valid: 1'b1,
                                 done_res: 1'b0, error: 1'b0, char_count: count_inc,
                                 last: (k_reg == '0)};
            end
            mag_next = rem;
            k_next   = k_reg - K_W'(1);
            if (k_reg == '0)
                state_next = S_IDLE;
        end

        if ((state_reg == S_NULDONE) && slot_free)
        begin
            load         = 1'b1;
            out_next     = '{out_char: CH_NUL, char_valid: 1'b0, done_res: 1'b1,
                             error: 1'b0, char_count: count_reg, last: 1'b1};
            count_next   = '0;
            pending_next = 1'b0;
            halted_next  = 1'b0;
            state_next   = S_IDLE;
        end

        out_valid_next = load ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pending_reg   <= 1'b0;
            halted_reg    <= 1'b0;
            count_reg     <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            halted_reg    <= halted_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_ch_reg  <= hold_ch_next;
        hold_arg_reg <= hold_arg_next;
        mag_reg      <= mag_next;
        k_reg        <= k_next;
        out_reg      <= out_next;
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.out_char   = out_reg.out_char;
    assign res_out.char_valid = out_reg.char_valid;
    assign res_out.done_res   = out_reg.done_res;
    assign res_out.error      = out_reg.error;
    assign res_out.char_count = out_reg.char_count;
    assign res_out.last       = out_reg.last;

    // running magnitude always below ten times the current digit weight
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIGIT) |->
            (MULT_W'(mag_reg) < MULT_W'(pow10_sat(int'(k_reg))) * MULT_W'(DFP_RADIX)))
        else $error("digit step magnitude out of range");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(pending_reg && halted_reg))
        else $error("percent pending while halted");

    // a waiting done beat sees cleared string state
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.done_res) |->
            ((count_reg == '0) && !pending_reg && !halted_reg))
        else $error("state not cleared behind done beat");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signed decimal format printer. A short table
// of format bytes covers the echo, %d at the argument extremes, bad
// conversions, halting until NUL and NUL after a lone percent sign. It is
// followed by random format strings that are mostly well formed, with some
// noise. Every result beat is checked field by field, against the table or an
// in-bench formatter, with random stalls on both channels, one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
    import dfp_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] c;
        logic [DATA_W-1:0] a;
        bit                typed;
        dfp_result_t       want;
    } dir_row_t;

    localparam dfp_result_t NO_BEAT = '0;
    localparam int N_DIR = 25;
    localparam int N_RAND = 255;
    localparam int LONG_HOLD = 60;

    logic clk;
    logic rst_n;

    dfp_in_if  fmt_bus ();
    dfp_out_if res_bus ();

    decimal_format_printer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .fmt_in  (fmt_bus),
        .res_out (res_bus)
    );

    // formatter state
    bit                pct_armed;
    bit                halted;
    logic [DATA_W-1:0] emit_cnt;

    dfp_result_t step_beats [$];
    dfp_result_t want_beats [$];

    int  bad_beats;
    int  sent;
    bit  quiet;
    bit  hold_req;

    dir_row_t plan [N_DIR] = '{
        '{8'h41,      32'h0000_0000, 1'b1, '{8'h41, 1'b1, 1'b0, 1'b0, 32'd1, 1'b1}},
        '{8'hFF,      32'hFFFF_FFFF, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd2, 1'b1}},
        '{8'h01,      32'h0000_0000, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0, 32'd3, 1'b1}},
        '{CH_PERCENT, 32'h7FFF_FFFF, 1'b0, NO_BEAT},
        '{CH_D,       32'h0000_0000, 1'b1, '{CH_ZERO, 1'b1, 1'b0, 1'b0, 32'd4, 1'b1}},
        '{CH_NUL,     32'h8000_0000, 1'b1, '{CH_NUL, 1'b0, 1'b1, 1'b0, 32'd4, 1'b1}},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_D,       32'h8000_0000, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_D,       32'h7FFF_FFFF, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_D,       32'hFFFF_FFFF, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_D,       32'd1000000000, 1'b0, NO_BEAT},
        '{CH_NUL,     32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b1, '{CH_PERCENT, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1}},
        '{8'h78,      32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_D,       32'h0000_0007, 1'b0, NO_BEAT},
        '{CH_NUL,     32'h0000_0000, 1'b1, '{CH_NUL, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1}},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_NUL,     32'h0000_0000, 1'b0, NO_BEAT},
        '{CH_PERCENT, 32'h0000_0000, 1'b0, NO_BEAT},
        '{8'h71,      32'h0000_0000, 1'b1, '{8'h71, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1}},
        '{CH_NUL,     32'h0000_0000, 1'b1, '{CH_NUL, 1'b0, 1'b1, 1'b0, 32'd0, 1'b1}}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint unsigned tens(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++)
        begin
            p = p * DFP_RADIX;
        end
        return p;
    endfunction

    function automatic void push_beat(input logic [CHAR_W-1:0] ch, input bit vld,
                                      input bit dn, input bit err);
        dfp_result_t b;
        b.out_char   = ch;
        b.char_valid = vld;
        b.done_res   = dn;
        b.error      = err;
        b.char_count = emit_cnt;
        b.last       = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic void emit(input logic [CHAR_W-1:0] ch);
        if (emit_cnt != '1)
        begin
            emit_cnt = emit_cnt + 1;
        end
        push_beat(ch, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void format_step(input logic [CHAR_W-1:0] c,
                                        input logic [DATA_W-1:0] a);
        longint unsigned mag;
        longint unsigned p;
        longint unsigned dg;
        int nd;
        step_beats.delete();
        if (c == CH_NUL)
        begin
            if (pct_armed && !halted)
            begin
                push_beat(CH_NUL, 1'b0, 1'b0, 1'b1);
            end
            push_beat(CH_NUL, 1'b0, 1'b1, 1'b0);
            pct_armed = 1'b0;
            halted    = 1'b0;
            emit_cnt  = '0;
        end
        else if (!halted)
        begin
            if (pct_armed)
            begin
                pct_armed = 1'b0;
                if (c == CH_D)
                begin
                    if (a[DATA_W-1])
                    begin
                        mag = 64'h1_0000_0000 - longint'(a);
                        emit(CH_MINUS);
                    end
                    else
                    begin
                        mag = longint'(a);
                    end
                    if (DFP_MAX_DIGITS < 19 && mag > tens(DFP_MAX_DIGITS) - 1)
                    begin
                        mag = tens(DFP_MAX_DIGITS) - 1;
                    end
                    nd = 1;
                    while (nd < DFP_MAX_DIGITS && nd < 19 && mag >= tens(nd))
                    begin
                        nd++;
                    end
                    for (int k = nd - 1; k >= 0; k--)
                    begin
                        p = tens(k);
                        dg = mag / p;
                        mag = mag % p;
                        if (dg > 9)
                        begin
                            dg = 9;
                        end
                        emit(CH_ZERO + CHAR_W'(dg));
                    end
                end
                else
                begin
                    halted = 1'b1;
                    push_beat(c, 1'b0, 1'b0, 1'b1);
                end
            end
            else if (c == CH_PERCENT)
            begin
                pct_armed = 1'b1;
            end
            else
            begin
                emit(c);
            end
        end
        if (step_beats.size() > 0)
        begin
            step_beats[step_beats.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic flag_beat(input string what, input logic [DATA_W-1:0] got,
                             input logic [DATA_W-1:0] exp);
        if (bad_beats < 40)
        begin
            $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
        end
        bad_beats++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic [DATA_W-1:0] a,
                             input bit typed, input dfp_result_t want);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            fmt_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fmt_bus.valid     <= 1'b1;
        fmt_bus.fmt_char  <= c;
        fmt_bus.arg_value <= a;
        do
            @(posedge clk);
        while (!fmt_bus.ready);
        format_step(c, a);
        if (typed)
        begin
            want_beats.push_back(want);
        end
        else
        begin
            foreach (step_beats[i])
            begin
                want_beats.push_back(step_beats[i]);
            end
        end
        sent++;
    endtask

    function automatic logic [DATA_W-1:0] pick_arg();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            3:
            begin
                v = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 1)
                begin
                    v = -v;
                end
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do
            c = CHAR_W'($urandom_range(1, 255));
        while (c == CH_PERCENT);
        return c;
    endfunction

    // result side: random ready bursts and one long hold
    initial
    begin
        int hold_cnt;
        bit hold_done;
        hold_cnt  = 0;
        hold_done = 1'b0;
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                res_bus.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_cnt  = LONG_HOLD - 1;
                res_bus.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                hold_cnt = $urandom_range(1, 4) - 1;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        dfp_result_t got;
        dfp_result_t exp;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            got.out_char   = res_bus.out_char;
            got.char_valid = res_bus.char_valid;
            got.done_res   = res_bus.done_res;
            got.error      = res_bus.error;
            got.char_count = res_bus.char_count;
            got.last       = res_bus.last;
            if (want_beats.size() == 0)
            begin
                flag_beat("unexpected beat, out_char", DATA_W'(got.out_char), '0);
            end
            else
            begin
                exp = want_beats.pop_front();
                if (got.out_char !== exp.out_char)
                    flag_beat("out_char", DATA_W'(got.out_char), DATA_W'(exp.out_char));
                if (got.char_valid !== exp.char_valid)
                    flag_beat("char_valid", DATA_W'(got.char_valid),
                              DATA_W'(exp.char_valid));
                if (got.done_res !== exp.done_res)
                    flag_beat("done_res", DATA_W'(got.done_res), DATA_W'(exp.done_res));
                if (got.error !== exp.error)
                    flag_beat("error", DATA_W'(got.error), DATA_W'(exp.error));
                if (got.char_count !== exp.char_count)
                    flag_beat("char_count", got.char_count, exp.char_count);
                if (got.last !== exp.last)
                    flag_beat("last", DATA_W'(got.last), DATA_W'(exp.last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        int nseg;
        int r;
        bit paused;
        logic [CHAR_W-1:0] bad;
        pct_armed = 1'b0;
        halted    = 1'b0;
        emit_cnt  = '0;
        bad_beats = 0;
        sent      = 0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        paused    = 1'b0;
        rst_n = 1'b0;
        fmt_bus.valid     <= 1'b0;
        fmt_bus.fmt_char  <= '0;
        fmt_bus.arg_value <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_char(plan[i].c, plan[i].a, plan[i].typed, plan[i].want);
        end

        sent = 0;
        while (sent < N_RAND)
        begin
            if (sent >= 90)
            begin
                hold_req = 1'b1;
            end
            if (sent >= 180 && !paused)
            begin
                paused = 1'b1;
                fmt_bus.valid <= 1'b0;
                do
                    @(posedge clk);
                while (want_beats.size() != 0);
            end
            if (sent >= 220)
            begin
                quiet = 1'b1;
            end
            nseg = $urandom_range(0, 6);
            for (int s = 0; s < nseg; s++)
            begin
                r = $urandom_range(0, 19);
                if (r < 11)
                begin
                    send_char(plain_char(), $urandom, 1'b0, NO_BEAT);
                end
                else if (r < 17)
                begin
                    send_char(CH_PERCENT, $urandom, 1'b0, NO_BEAT);
                    send_char(CH_D, pick_arg(), 1'b0, NO_BEAT);
                end
                else if (r < 19)
                begin
                    do
                        bad = CHAR_W'($urandom_range(0, 255));
                    while (bad == CH_D);
                    send_char(CH_PERCENT, $urandom, 1'b0, NO_BEAT);
                    send_char(bad, $urandom, 1'b0, NO_BEAT);
                end
                else
                begin
                    send_char(CHAR_W'($urandom_range(0, 255)), $urandom, 1'b0, NO_BEAT);
                end
            end
            send_char(CH_NUL, $urandom, 1'b0, NO_BEAT);
        end
        fmt_bus.valid <= 1'b0;

        while (want_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (bad_beats == 0 && want_beats.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
